// ===== design/xcfd_pkg.sv =====
// ----------------------------------------------------------------------------
// xcfd_pkg
// Shared types and constants for the XOR-checked frame deframer.
// ----------------------------------------------------------------------------
package xcfd_pkg;

    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 1;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'h80;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h81;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_FIRST  = 1'b0,
        CFG_HEADER_SECOND = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_HDR1 = 3'd0,
        PH_HDR2 = 3'd1,
        PH_SRC  = 3'd2,
        PH_TYPE = 3'd3,
        PH_LEN  = 3'd4,
        PH_DATA = 3'd5,
        PH_SUM  = 3'd6
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] source_id;
        logic [BYTE_W-1:0] message_type;
        logic [BYTE_W-1:0] payload_length;
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] byte_index;
        logic              frame_end;
        logic              checksum_good;
        logic              link_seen;
    } res_t;

endpackage

// ===== design/xcfd_parser.sv =====
// ----------------------------------------------------------------------------
// xcfd_parser
// Input register and frame parser: header hunt, field capture, running XOR.
// ----------------------------------------------------------------------------
module xcfd_parser
    import xcfd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_rx_byte,
    input  logic [BYTE_W-1:0] header_first,
    input  logic [BYTE_W-1:0] header_second,
    input  logic              out_free,
    output logic              res_valid,
    output res_t              res
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] source_reg, source_next;
    logic [BYTE_W-1:0] type_reg, type_next;
    logic [BYTE_W-1:0] length_reg, length_next;
    logic [BYTE_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic              link_reg, link_next;

    logic              has_result;
    logic              advance;
    logic [BYTE_W:0]   count_inc;
    logic              good;

    assign has_result = (phase_reg == PH_DATA) || (phase_reg == PH_SUM);
    assign advance    = in_valid_reg && (!has_result || out_free);
    assign s_ready    = !in_valid_reg || advance;
    assign count_inc  = {1'b0, count_reg} + {{BYTE_W{1'b0}}, 1'b1};
    assign good       = (in_byte_reg == xor_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HDR2: begin
                if (in_byte_reg == header_second) begin
                    phase_next = PH_SRC;
                end else if (in_byte_reg == header_first) begin
                    phase_next = PH_HDR2;
                end else begin
                    phase_next = PH_HDR1;
                end
            end
            PH_SRC:  phase_next = PH_TYPE;
            PH_TYPE: phase_next = PH_LEN;
            PH_LEN: begin
                phase_next = (in_byte_reg == '0) ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
                if (count_inc >= {1'b0, length_reg}) begin
                    phase_next = PH_SUM;
                end
            end
            PH_SUM:  phase_next = PH_HDR1;
            default: begin
                phase_next = (in_byte_reg == header_first) ? PH_HDR2 : PH_HDR1;
            end
        endcase
    end

    always_comb begin
        source_next = source_reg;
        type_next   = type_reg;
        length_next = length_reg;
        count_next  = count_reg;
        xor_next    = xor_reg;
        link_next   = link_reg;
        res_valid   = 1'b0;
        res         = '{source_id:      source_reg,
                        message_type:   type_reg,
                        payload_length: length_reg,
                        payload_valid:  1'b0,
                        payload_byte:   '0,
                        byte_index:     '0,
                        frame_end:      1'b0,
                        checksum_good:  1'b0,
                        link_seen:      link_reg};
        case (phase_reg)
            PH_HDR2: begin
                if (in_byte_reg == header_second) begin
                    xor_next = xor_reg ^ in_byte_reg;
                end else if (in_byte_reg == header_first) begin
                    xor_next = in_byte_reg;
                end
            end
            PH_SRC: begin
                source_next = in_byte_reg;
                xor_next    = xor_reg ^ in_byte_reg;
            end
            PH_TYPE: begin
                type_next = in_byte_reg;
                xor_next  = xor_reg ^ in_byte_reg;
            end
            PH_LEN: begin
                length_next = in_byte_reg;
                xor_next    = xor_reg ^ in_byte_reg;
                count_next  = '0;
            end
            PH_DATA: begin
                xor_next          = xor_reg ^ in_byte_reg;
                count_next        = count_inc[BYTE_W-1:0];
                res_valid         = advance;
                res.payload_valid = 1'b1;
                res.payload_byte  = in_byte_reg;
                res.byte_index    = count_reg;
            end
            PH_SUM: begin
                if (good) begin
                    link_next = 1'b1;
                end
                res_valid         = advance;
                res.frame_end     = 1'b1;
                res.checksum_good = good;
                res.link_seen     = link_reg | good;
            end
            default: begin
                if (in_byte_reg == header_first) begin
                    xor_next = in_byte_reg;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR1;
            source_reg <= '0;
            type_reg   <= '0;
            length_reg <= '0;
            count_reg  <= '0;
            xor_reg    <= '0;
            link_reg   <= 1'b0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            source_reg <= source_next;
            type_reg   <= type_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            xor_reg    <= xor_next;
            link_reg   <= link_next;
        end
    end

`ifndef SYNTH
    a_sum_returns_to_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (phase_reg == PH_SUM) |=> phase_reg == PH_HDR1)
        else $error("phase did not return to hunt after checksum byte");

    a_link_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        link_reg |=> link_reg)
        else $error("link flag cleared without reset");

    a_result_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> out_free && in_valid_reg)
        else $error("result produced while output register busy");

    a_count_within_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> count_reg < length_reg)
        else $error("payload count reached length while in payload phase");
`endif

endmodule

// ===== design/xcfd_out_reg.sv =====
// ----------------------------------------------------------------------------
// xcfd_out_reg
// Result register holding one item until the downstream side takes it.
// ----------------------------------------------------------------------------
module xcfd_out_reg
    import xcfd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic res_valid,
    input  res_t res,
    output logic out_free,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_res
);

    logic valid_reg;
    res_t data_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= res_valid;
        end
        if (res_valid && out_free) begin
            data_reg <= res;
        end
    end

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !m_ready |=> valid_reg && $stable(data_reg))
        else $error("held result lost or changed under backpressure");

    a_end_has_no_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> !(data_reg.frame_end && data_reg.payload_valid))
        else $error("result flagged as both payload and frame end");

    a_good_only_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && data_reg.checksum_good |-> data_reg.frame_end && data_reg.link_seen)
        else $error("checksum good outside a closing item");
`endif

endmodule

// ===== design/xor_checked_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// xor_checked_frame_deframer
// Byte-stream deframer for two-byte-header frames with an XOR checksum.
// ----------------------------------------------------------------------------
// Each received byte enters an input register and is then parsed by one pass
// of compare, XOR and phase logic into a result register, so the block takes
// one byte per clock cycle, unless a payload or checksum byte must wait for a
// held result to be taken. Header, source, type and length bytes give no
// result item; each payload byte gives one item, and the checksum byte gives
// one closing item with the checksum flag and the sticky link flag. The header
// bytes are set through the configuration port, which is always ready.
module xor_checked_frame_deframer
    import xcfd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_rx_byte,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [BYTE_W-1:0]    m_source_id,
    output logic [BYTE_W-1:0]    m_message_type,
    output logic [BYTE_W-1:0]    m_payload_length,
    output logic                 m_payload_valid,
    output logic [BYTE_W-1:0]    m_payload_byte,
    output logic [BYTE_W-1:0]    m_byte_index,
    output logic                 m_frame_end,
    output logic                 m_checksum_good,
    output logic                 m_link_seen
);

    logic [BYTE_W-1:0] header_first_reg;
    logic [BYTE_W-1:0] header_second_reg;
    logic              out_free;
    logic              res_valid;
    res_t              res;
    res_t              m_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_first_reg  <= HEADER_FIRST_RST;
            header_second_reg <= HEADER_SECOND_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_HEADER_FIRST:  header_first_reg  <= cfg_data;
                CFG_HEADER_SECOND: header_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    xcfd_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .header_first  (header_first_reg),
        .header_second (header_second_reg),
        .out_free      (out_free),
        .res_valid     (res_valid),
        .res           (res)
    );

    xcfd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_source_id      = m_res.source_id;
    assign m_message_type   = m_res.message_type;
    assign m_payload_length = m_res.payload_length;
    assign m_payload_valid  = m_res.payload_valid;
    assign m_payload_byte   = m_res.payload_byte;
    assign m_byte_index     = m_res.byte_index;
    assign m_frame_end      = m_res.frame_end;
    assign m_checksum_good  = m_res.checksum_good;
    assign m_link_seen      = m_res.link_seen;

endmodule
